/* hdl/solar_differential_pump_control_defines.svh */
`ifndef SOLAR_DIFFERENTIAL_PUMP_CONTROL_DEFINES_SVH
`define SOLAR_DIFFERENTIAL_PUMP_CONTROL_DEFINES_SVH

// same-cycle implication, reset masked
`define SDPC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdpc check failed");

// next-cycle implication, reset masked
`define SDPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdpc check failed");

`endif

/* hdl/sdpc_pkg.sv */
package sdpc_pkg;

  localparam int TEMP_W  = 13;
  localparam int CNT_W   = 63;
  localparam int MUL_W   = 25;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [8:0]        HEAT_FACTOR  = 9'd419;
  localparam logic signed [13:0] STORE_MARGIN = 14'sd50;
  localparam logic [CNT_W-1:0]  CNT_MAX      = {CNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_SOLAR_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_EN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_ON   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_OFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLL_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STORE_LIM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW      = 3'd6;

  // counter slots
  localparam logic [1:0] SLOT_DAY   = 2'd0;
  localparam logic [1:0] SLOT_MONTH = 2'd1;
  localparam logic [1:0] SLOT_YEAR  = 2'd2;
  localparam logic [1:0] SLOT_TOTAL = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_ADD,
    ST_DATE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic              fault;
    logic              protect;
    logic              want;
    logic              gain;
    logic [TEMP_W-1:0] diff_mag;
  } eval_t;

endpackage

/* hdl/sdpc_eval.sv */
module sdpc_eval
  import sdpc_pkg::*;
(
  input  logic signed [TEMP_W-1:0] coll_temp,
  input  logic                     coll_ok,
  input  logic signed [TEMP_W-1:0] buf_temp,
  input  logic                     buf_ok,
  input  logic signed [TEMP_W-1:0] dhw_temp,
  input  logic                     dhw_ok,
  input  logic                     buffer_en,
  input  logic [8:0]               diff_on,
  input  logic signed [9:0]        diff_off,
  input  logic [11:0]              coll_limit,
  input  logic [10:0]              store_limit,
  input  logic                     pump_state,
  output eval_t                    res
);

  logic                     use_buf;
  logic                     store_ok;
  logic signed [TEMP_W-1:0] store;
  logic signed [13:0]       coll_x;
  logic signed [13:0]       store_x;
  logic signed [13:0]       diff;
  logic signed [13:0]       on_x;
  logic signed [13:0]       off_x;
  logic signed [13:0]       clim_x;
  logic signed [13:0]       slim_x;
  logic signed [13:0]       slim_m;
  logic                     protect;
  logic                     want;

  always_comb begin
    use_buf  = buffer_en && buf_ok;
    store    = use_buf ? buf_temp : dhw_temp;
    store_ok = use_buf || dhw_ok;
    coll_x   = {coll_temp[TEMP_W-1], coll_temp};
    store_x  = {store[TEMP_W-1], store};
    diff     = coll_x - store_x;
    on_x     = {5'b0, diff_on};
    off_x    = {{4{diff_off[9]}}, diff_off};
    clim_x   = {2'b0, coll_limit};
    slim_x   = {3'b0, store_limit};
    slim_m   = slim_x + STORE_MARGIN;
    protect  = coll_x >= clim_x;
    want     = pump_state;
    if (diff >= on_x) begin
      want = 1'b1;
    end
    if (diff <= off_x) begin
      want = 1'b0;
    end
    if (store_x >= slim_x && !protect) begin
      want = 1'b0;
    end
    if (protect && store_x < slim_m) begin
      want = 1'b1;
    end
    res.fault    = !coll_ok || !store_ok;
    res.protect  = protect;
    res.want     = want;
    res.gain     = want && (diff > 14'sd0);
    res.diff_mag = diff[TEMP_W-1:0];
  end

endmodule

/* hdl/sdpc_mul.sv */
module sdpc_mul
  import sdpc_pkg::*;
(
  input  logic [MUL_W-1:0]  op_a,
  input  logic [MUL_W-1:0]  op_b,
  output logic [PROD_W-1:0] prod
);

  assign prod = PROD_W'(op_a) * PROD_W'(op_b);

endmodule

/* hdl/solar_differential_pump_control.sv */
// Sequence: EVAL, then FIN when disabled or faulted; EVAL, DATE, FIN without energy gain;
// with gain EVAL, MUL_A, MUL_B, MUL_C (three passes through one 25x25 multiplier), ADD
// four times (one 63-bit saturating adder), DATE, FIN. in_stall holds new requests until
// FIN loads the result; the next request may enter while a result waits on out_stall.
// Reset (synchronous, rst_n low): counters, date marks and pump state cleared,
// registers back to defaults, no result pending.
module solar_differential_pump_control
  import sdpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [TEMP_W-1:0] in_collector_temp,
  input  logic                     in_collector_valid,
  input  logic signed [TEMP_W-1:0] in_buffer_bottom_temp,
  input  logic                     in_buffer_valid,
  input  logic signed [TEMP_W-1:0] in_dhw_temp,
  input  logic                     in_dhw_valid,
  input  logic [15:0]              in_elapsed_ms,
  input  logic [8:0]               in_day_of_year,
  input  logic [3:0]               in_month_index,
  input  logic [7:0]               in_year_index,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_pump_on,
  output logic                     out_collector_over_max,
  output logic                     out_sensor_fault,
  output logic [CNT_W-1:0]         out_yield_today,
  output logic [CNT_W-1:0]         out_yield_this_month,
  output logic [CNT_W-1:0]         out_yield_this_year,
  output logic [CNT_W-1:0]         out_yield_overall
);

  state_t state_r, state_nxt;

  logic              solar_en_r, buffer_en_r;
  logic [8:0]        diff_on_r;
  logic signed [9:0] diff_off_r;
  logic [11:0]       coll_lim_r;
  logic [10:0]       store_lim_r;
  logic [9:0]        flow_r;

  logic signed [TEMP_W-1:0] coll_r, buf_r, dhw_r;
  logic                     coll_ok_r, buf_ok_r, dhw_ok_r;
  logic [15:0]              ms_r;
  logic [8:0]               day_r;
  logic [3:0]               mon_r;
  logic [7:0]               yr_r;

  logic              pump_state_r, pump_state_nxt;
  logic [CNT_W-1:0]  en_r [4];
  logic [CNT_W-1:0]  en_nxt [4];
  logic [8:0]        last_day_r, last_day_nxt;
  logic [3:0]        last_mon_r, last_mon_nxt;
  logic [7:0]        last_yr_r, last_yr_nxt;
  logic [1:0]        slot_r, slot_nxt;

  logic              res_pump_r, res_pump_nxt;
  logic              res_prot_r, res_prot_nxt;
  logic              res_fault_r, res_fault_nxt;
  logic [TEMP_W-1:0] diff_r, diff_nxt;
  logic [MUL_W-1:0]  op_r, op_nxt;
  logic [PROD_W-1:0] e_r, e_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_load;

  logic              accept;
  eval_t             ev;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [CNT_W:0]    sum;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  sdpc_eval u_eval (
    .coll_temp   (coll_r),
    .coll_ok     (coll_ok_r),
    .buf_temp    (buf_r),
    .buf_ok      (buf_ok_r),
    .dhw_temp    (dhw_r),
    .dhw_ok      (dhw_ok_r),
    .buffer_en   (buffer_en_r),
    .diff_on     (diff_on_r),
    .diff_off    (diff_off_r),
    .coll_limit  (coll_lim_r),
    .store_limit (store_lim_r),
    .pump_state  (pump_state_r),
    .res         (ev)
  );

  sdpc_mul u_mul (
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (mul_p)
  );

  assign sum = {1'b0, en_r[slot_r]} + (CNT_W + 1)'(e_r);

  always_comb begin
    state_nxt      = state_r;
    pump_state_nxt = pump_state_r;
    for (int i = 0; i < 4; i++) begin
      en_nxt[i] = en_r[i];
    end
    last_day_nxt  = last_day_r;
    last_mon_nxt  = last_mon_r;
    last_yr_nxt   = last_yr_r;
    slot_nxt      = slot_r;
    res_pump_nxt  = res_pump_r;
    res_prot_nxt  = res_prot_r;
    res_fault_nxt = res_fault_r;
    diff_nxt      = diff_r;
    op_nxt        = op_r;
    e_nxt         = e_r;
    mul_a         = MUL_W'(ms_r);
    mul_b         = MUL_W'(HEAT_FACTOR);
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        res_pump_nxt  = 1'b0;
        res_prot_nxt  = 1'b0;
        res_fault_nxt = 1'b0;
        diff_nxt      = ev.diff_mag;
        slot_nxt      = SLOT_DAY;
        if (!solar_en_r) begin
          state_nxt = ST_FIN;
        end else if (ev.fault) begin
          res_fault_nxt  = 1'b1;
          pump_state_nxt = 1'b0;
          state_nxt      = ST_FIN;
        end else begin
          res_pump_nxt   = ev.want;
          res_prot_nxt   = ev.protect;
          pump_state_nxt = ev.want;
          state_nxt      = ev.gain ? ST_MUL_A : ST_DATE;
        end
      end
      ST_MUL_A: begin
        op_nxt    = mul_p[MUL_W-1:0];
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        mul_a     = MUL_W'(flow_r);
        mul_b     = MUL_W'(diff_r);
        e_nxt     = mul_p;
        state_nxt = ST_MUL_C;
      end
      ST_MUL_C: begin
        mul_a     = op_r;
        mul_b     = e_r[MUL_W-1:0];
        e_nxt     = mul_p;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        en_nxt[slot_r] = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
        slot_nxt       = slot_r + 2'd1;
        if (slot_r == SLOT_TOTAL) begin
          state_nxt = ST_DATE;
        end
      end
      ST_DATE: begin
        if (last_day_r != day_r) begin
          last_day_nxt     = day_r;
          en_nxt[SLOT_DAY] = '0;
        end
        if (last_mon_r != mon_r) begin
          last_mon_nxt       = mon_r;
          en_nxt[SLOT_MONTH] = '0;
        end
        if (last_yr_r != yr_r) begin
          last_yr_nxt       = yr_r;
          en_nxt[SLOT_YEAR] = '0;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      solar_en_r   <= 1'b0;
      buffer_en_r  <= 1'b0;
      diff_on_r    <= 9'd60;
      diff_off_r   <= 10'sd30;
      coll_lim_r   <= 12'd1200;
      store_lim_r  <= 11'd800;
      flow_r       <= 10'd50;
      pump_state_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        en_r[i] <= '0;
      end
      last_day_r  <= '0;
      last_mon_r  <= '0;
      last_yr_r   <= '0;
      slot_r      <= SLOT_DAY;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pump_state_r <= pump_state_nxt;
      for (int i = 0; i < 4; i++) begin
        en_r[i] <= en_nxt[i];
      end
      last_day_r  <= last_day_nxt;
      last_mon_r  <= last_mon_nxt;
      last_yr_r   <= last_yr_nxt;
      slot_r      <= slot_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SOLAR_EN:  solar_en_r  <= cfg_data[0];
          CFG_BUFFER_EN: buffer_en_r <= cfg_data[0];
          CFG_DIFF_ON:   diff_on_r   <= cfg_data[8:0];
          CFG_DIFF_OFF:  diff_off_r  <= cfg_data[9:0];
          CFG_COLL_LIM:  coll_lim_r  <= cfg_data[11:0];
          CFG_STORE_LIM: store_lim_r <= cfg_data[10:0];
          CFG_FLOW:      flow_r      <= cfg_data[9:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      coll_r    <= in_collector_temp;
      coll_ok_r <= in_collector_valid;
      buf_r     <= in_buffer_bottom_temp;
      buf_ok_r  <= in_buffer_valid;
      dhw_r     <= in_dhw_temp;
      dhw_ok_r  <= in_dhw_valid;
      ms_r      <= in_elapsed_ms;
      day_r     <= in_day_of_year;
      mon_r     <= in_month_index;
      yr_r      <= in_year_index;
    end
    res_pump_r  <= res_pump_nxt;
    res_prot_r  <= res_prot_nxt;
    res_fault_r <= res_fault_nxt;
    diff_r      <= diff_nxt;
    op_r        <= op_nxt;
    e_r         <= e_nxt;
    if (out_load) begin
      out_pump_on            <= res_pump_r;
      out_collector_over_max <= res_prot_r;
      out_sensor_fault       <= res_fault_r;
      out_yield_today        <= en_r[SLOT_DAY];
      out_yield_this_month   <= en_r[SLOT_MONTH];
      out_yield_this_year    <= en_r[SLOT_YEAR];
      out_yield_overall      <= en_r[SLOT_TOTAL];
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/sdpc_checker.sv */
`include "solar_differential_pump_control_defines.svh"

module sdpc_checker
  import sdpc_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     out_pump_on,
  input logic                     out_collector_over_max,
  input logic                     out_sensor_fault,
  input logic [CNT_W-1:0]         out_yield_today,
  input logic [CNT_W-1:0]         out_yield_this_year,
  input logic [CNT_W-1:0]         out_yield_overall
);

  // a fault result never drives the pump or warns
  `SDPC_ASSERT_NOW(a_fault_quiet, out_valid && out_sensor_fault, !out_pump_on && !out_collector_over_max)

  // lifetime total never falls behind the daily or yearly count
  `SDPC_ASSERT_NOW(a_total_day, out_valid, out_yield_overall >= out_yield_today)
  `SDPC_ASSERT_NOW(a_total_year, out_valid, out_yield_overall >= out_yield_this_year)

  // one request at a time
  `SDPC_ASSERT_NEXT(a_busy, in_valid && !in_stall, in_stall)

  // stalled result holds
  `SDPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_yield_overall))

endmodule

bind solar_differential_pump_control sdpc_checker u_sdpc_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_pump_on            (out_pump_on),
  .out_collector_over_max (out_collector_over_max),
  .out_sensor_fault       (out_sensor_fault),
  .out_yield_today        (out_yield_today),
  .out_yield_this_year    (out_yield_this_year),
  .out_yield_overall      (out_yield_overall)
);

/* sim/tb_solar_differential_pump_control.sv */
`timescale 1ns / 1ps

module tb_solar_differential_pump_control;
  import sdpc_pkg::*;

  typedef struct {
    logic                     solar_en;
    logic                     buffer_en;
    logic [8:0]               diff_on;
    logic signed [9:0]        diff_off;
    logic [11:0]              coll_limit;
    logic [10:0]              store_limit;
    logic [9:0]               flow;
  } loop_cfg_t;

  typedef struct {
    logic signed [TEMP_W-1:0] coll;
    logic                     coll_ok;
    logic signed [TEMP_W-1:0] buffer_temp;
    logic                     buffer_ok;
    logic signed [TEMP_W-1:0] dhw;
    logic                     dhw_ok;
    logic [15:0]              ms;
    logic [8:0]               day;
    logic [3:0]               month;
    logic [7:0]               year;
  } tick_t;

  typedef struct {
    logic                     pump;
    logic                     over_max;
    logic                     fault;
    logic [CNT_W-1:0]         today;
    logic [CNT_W-1:0]         month_yield;
    logic [CNT_W-1:0]         year_yield;
    logic [CNT_W-1:0]         overall;
  } meter_t;

  class pump_scoreboard;
    loop_cfg_t        cfg;
    logic             pump_state;
    logic [CNT_W-1:0] e_day, e_month, e_year, e_total;
    logic [8:0]       mark_day;
    logic [3:0]       mark_month;
    logic [7:0]       mark_year;
    meter_t           expected_meters[$];
    int               errors;
    int               ticks;
    int               checked;
    int               saturated;

    function new();
      cfg = '{1'b0, 1'b0, 9'd60, 10'sd30, 12'd1200, 11'd800, 10'd50};
      pump_state = 1'b0;
      e_day = '0;
      e_month = '0;
      e_year = '0;
      e_total = '0;
      mark_day = '0;
      mark_month = '0;
      mark_year = '0;
      errors = 0;
      ticks = 0;
      checked = 0;
      saturated = 0;
    endfunction

    function logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {2'b00, a} + {1'b0, b};
      return (s > {2'b00, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    function void note_tick(tick_t t);
      meter_t     m;
      int         store;
      int         diff;
      logic       store_ok;
      logic       want;
      logic [63:0] gain;
      m.pump = 1'b0;
      m.over_max = 1'b0;
      m.fault = 1'b0;
      ticks++;
      if (cfg.solar_en) begin
        store = t.dhw;
        store_ok = t.dhw_ok;
        if (cfg.buffer_en && t.buffer_ok) begin
          store = t.buffer_temp;
          store_ok = 1'b1;
        end
        if (!t.coll_ok || !store_ok) begin
          m.fault = 1'b1;
          pump_state = 1'b0;
        end else begin
          diff = int'(t.coll) - store;
          want = pump_state;
          m.over_max = int'(t.coll) >= int'(cfg.coll_limit);
          if (diff >= int'(cfg.diff_on)) want = 1'b1;
          if (diff <= int'(cfg.diff_off)) want = 1'b0;
          if (store >= int'(cfg.store_limit) && !m.over_max) want = 1'b0;
          if (m.over_max && store < int'(cfg.store_limit) + int'(STORE_MARGIN)) want = 1'b1;
          pump_state = want;
          m.pump = want;
          if (want && diff > 0) begin
            gain = 64'(cfg.flow) * 64'(diff) * 64'(t.ms) * 64'(HEAT_FACTOR);
            e_day = sat_add(e_day, gain);
            e_month = sat_add(e_month, gain);
            e_year = sat_add(e_year, gain);
            e_total = sat_add(e_total, gain);
          end
          // new date clears after the add
          if (mark_day != t.day) begin
            mark_day = t.day;
            e_day = '0;
          end
          if (mark_month != t.month) begin
            mark_month = t.month;
            e_month = '0;
          end
          if (mark_year != t.year) begin
            mark_year = t.year;
            e_year = '0;
          end
        end
      end
      m.today = e_day;
      m.month_yield = e_month;
      m.year_yield = e_year;
      m.overall = e_total;
      expected_meters.push_back(m);
    endfunction

    function void check_meter(meter_t got);
      meter_t exp_m;
      if (expected_meters.size() == 0) begin
        errors++;
        if (errors <= 10) $display("MISMATCH: result with no pending request");
        return;
      end
      exp_m = expected_meters.pop_front();
      checked++;
      if (got.overall == CNT_MAX) saturated++;
      if (got.pump !== exp_m.pump || got.over_max !== exp_m.over_max ||
          got.fault !== exp_m.fault || got.today !== exp_m.today ||
          got.month_yield !== exp_m.month_yield || got.year_yield !== exp_m.year_yield ||
          got.overall !== exp_m.overall) begin
        errors++;
        if (errors <= 10) begin
          $display("MISMATCH result %0d: expected pump=%0b over=%0b fault=%0b d=%0d m=%0d y=%0d t=%0d",
                   checked, exp_m.pump, exp_m.over_max, exp_m.fault, exp_m.today,
                   exp_m.month_yield, exp_m.year_yield, exp_m.overall);
          $display("  actual pump=%0b over=%0b fault=%0b d=%0d m=%0d y=%0d t=%0d",
                   got.pump, got.over_max, got.fault, got.today,
                   got.month_yield, got.year_yield, got.overall);
        end
      end
    endfunction

    function int pending();
      return expected_meters.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [TEMP_W-1:0] in_collector_temp = '0;
  logic                     in_collector_valid = 1'b0;
  logic signed [TEMP_W-1:0] in_buffer_bottom_temp = '0;
  logic                     in_buffer_valid = 1'b0;
  logic signed [TEMP_W-1:0] in_dhw_temp = '0;
  logic                     in_dhw_valid = 1'b0;
  logic [15:0]              in_elapsed_ms = '0;
  logic [8:0]               in_day_of_year = '0;
  logic [3:0]               in_month_index = '0;
  logic [7:0]               in_year_index = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_pump_on;
  logic                     out_collector_over_max;
  logic                     out_sensor_fault;
  logic [CNT_W-1:0]         out_yield_today;
  logic [CNT_W-1:0]         out_yield_this_month;
  logic [CNT_W-1:0]         out_yield_this_year;
  logic [CNT_W-1:0]         out_yield_overall;

  pump_scoreboard board;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int settings = 0;
  int cur_day = 0;
  int cur_month = 0;
  int cur_year = 0;

  solar_differential_pump_control dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_collector_temp      (in_collector_temp),
    .in_collector_valid     (in_collector_valid),
    .in_buffer_bottom_temp  (in_buffer_bottom_temp),
    .in_buffer_valid        (in_buffer_valid),
    .in_dhw_temp            (in_dhw_temp),
    .in_dhw_valid           (in_dhw_valid),
    .in_elapsed_ms          (in_elapsed_ms),
    .in_day_of_year         (in_day_of_year),
    .in_month_index         (in_month_index),
    .in_year_index          (in_year_index),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_pump_on            (out_pump_on),
    .out_collector_over_max (out_collector_over_max),
    .out_sensor_fault       (out_sensor_fault),
    .out_yield_today        (out_yield_today),
    .out_yield_this_month   (out_yield_this_month),
    .out_yield_this_year    (out_yield_this_year),
    .out_yield_overall      (out_yield_overall)
  );

  always #10 clk = ~clk;

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    tick_t  t;
    meter_t m;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        t.coll = in_collector_temp;
        t.coll_ok = in_collector_valid;
        t.buffer_temp = in_buffer_bottom_temp;
        t.buffer_ok = in_buffer_valid;
        t.dhw = in_dhw_temp;
        t.dhw_ok = in_dhw_valid;
        t.ms = in_elapsed_ms;
        t.day = in_day_of_year;
        t.month = in_month_index;
        t.year = in_year_index;
        board.note_tick(t);
      end
      if (out_valid && !out_stall) begin
        m.pump = out_pump_on;
        m.over_max = out_collector_over_max;
        m.fault = out_sensor_fault;
        m.today = out_yield_today;
        m.month_yield = out_yield_this_month;
        m.year_yield = out_yield_this_year;
        m.overall = out_yield_overall;
        board.check_meter(m);
      end
    end
  end

  function automatic tick_t mk(int coll, int buffer_temp, int dhw, logic [2:0] oks,
                               int ms, int day, int month, int year);
    tick_t t;
    t.coll = 13'(coll);
    t.buffer_temp = 13'(buffer_temp);
    t.dhw = 13'(dhw);
    {t.coll_ok, t.buffer_ok, t.dhw_ok} = oks;
    t.ms = 16'(ms);
    t.day = 9'(day);
    t.month = 4'(month);
    t.year = 8'(year);
    return t;
  endfunction

  function automatic loop_cfg_t rand_cfg();
    loop_cfg_t c;
    c.solar_en = ($urandom_range(99) < 85);
    c.buffer_en = 1'($urandom_range(1));
    c.diff_on = 9'($urandom_range(0, 500));
    c.diff_off = 10'($urandom_range(0, 700) - 200);
    c.coll_limit = 12'($urandom_range(0, 2500));
    c.store_limit = 11'($urandom_range(0, 1500));
    c.flow = 10'($urandom_range(0, 1000));
    return c;
  endfunction

  // heavy: steady date, huge difference and long interval for the largest gains
  function automatic tick_t rand_tick(bit heavy);
    tick_t t;
    int    r;
    int    base;
    if (!heavy) begin
      r = $urandom_range(99);
      if (r < 3) cur_day = $urandom_range(0, 365);
      else if (r < 5) cur_month = $urandom_range(0, 11);
      else if (r < 6) cur_year = $urandom_range(0, 255);
      else if (r < 7) begin
        cur_day = $urandom_range(0, 511);
        cur_month = $urandom_range(0, 15);
        cur_year = $urandom_range(0, 255);
      end
    end
    base = $urandom_range(0, 3000) - 500;
    t.dhw = 13'(base);
    t.buffer_temp = 13'($urandom_range(0, 3000) - 500);
    t.coll = 13'(base + $urandom_range(0, 1000) - 250);
    if ($urandom_range(9) == 0) t.coll = 13'($urandom);
    if ($urandom_range(9) == 0) t.dhw = 13'($urandom);
    if ($urandom_range(9) == 0) t.buffer_temp = 13'($urandom);
    t.coll_ok = ($urandom_range(99) < 94);
    t.buffer_ok = ($urandom_range(99) < 94);
    t.dhw_ok = ($urandom_range(99) < 94);
    t.ms = 16'($urandom);
    if (heavy) begin
      t.coll = 13'($urandom_range(3500, 4095));
      t.dhw = {1'b1, 12'($urandom_range(0, 596))};
      t.coll_ok = 1'b1;
      t.dhw_ok = 1'b1;
      t.ms = 16'($urandom_range(60000, 65535));
    end
    t.day = 9'(cur_day);
    t.month = 4'(cur_month);
    t.year = 8'(cur_year);
    return t;
  endfunction

  task automatic send_tick(tick_t t);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_collector_temp <= t.coll;
    in_collector_valid <= t.coll_ok;
    in_buffer_bottom_temp <= t.buffer_temp;
    in_buffer_valid <= t.buffer_ok;
    in_dhw_temp <= t.dhw;
    in_dhw_valid <= t.dhw_ok;
    in_elapsed_ms <= t.ms;
    in_day_of_year <= t.day;
    in_month_index <= t.month;
    in_year_index <= t.year;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(loop_cfg_t c);
    write_reg(CFG_SOLAR_EN, CFG_DATA_W'(c.solar_en));
    write_reg(CFG_BUFFER_EN, CFG_DATA_W'(c.buffer_en));
    write_reg(CFG_DIFF_ON, CFG_DATA_W'(c.diff_on));
    write_reg(CFG_DIFF_OFF, {2'b00, c.diff_off});
    write_reg(CFG_COLL_LIM, CFG_DATA_W'(c.coll_limit));
    write_reg(CFG_STORE_LIM, CFG_DATA_W'(c.store_limit));
    write_reg(CFG_FLOW, CFG_DATA_W'(c.flow));
    cfg_we <= 1'b0;
    board.cfg = c;
    settings++;
  endtask

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    loop_cfg_t c;
    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: loop disabled
    send_tick(mk(500, 0, 400, 3'b101, 1000, 0, 0, 0));
    settle();
    c = board.cfg;
    c.solar_en = 1'b1;
    apply_config(c);
    send_tick(mk(500, 0, 400, 3'b101, 1000, 0, 0, 0));
    send_tick(mk(450, 0, 400, 3'b101, 2000, 0, 0, 0));
    send_tick(mk(420, 0, 400, 3'b101, 500, 0, 0, 0));
    send_tick(mk(450, 0, 400, 3'b101, 500, 0, 0, 0));
    send_tick(mk(500, 0, 400, 3'b001, 500, 0, 0, 0));
    send_tick(mk(500, 400, 400, 3'b110, 500, 0, 0, 0));
    send_tick(mk(1000, 0, 800, 3'b101, 500, 0, 0, 0));
    send_tick(mk(1300, 0, 820, 3'b101, 3000, 0, 0, 0));
    send_tick(mk(1300, 0, 850, 3'b101, 3000, 0, 0, 0));
    send_tick(mk(1200, 0, 1300, 3'b101, 3000, 0, 0, 0));
    send_tick(mk(4095, 0, -4096, 3'b101, 65535, 0, 0, 0));
    send_tick(mk(-4096, 0, 4095, 3'b101, 65535, 0, 0, 0));
    send_tick(mk(900, 0, 300, 3'b101, 65535, 5, 0, 0));
    send_tick(mk(900, 0, 300, 3'b101, 0, 5, 3, 0));
    send_tick(mk(900, 0, 300, 3'b101, 40000, 511, 15, 255));
    send_tick(mk(900, 0, 300, 3'b101, 12345, 511, 15, 255));
    settle();
    // disabled while pumping keeps the pump state
    c.solar_en = 1'b0;
    apply_config(c);
    send_tick(mk(900, 0, 300, 3'b101, 12345, 0, 0, 0));
    settle();
    c.solar_en = 1'b1;
    apply_config(c);
    send_tick(mk(340, 0, 300, 3'b101, 1000, 511, 15, 255));
    settle();
    c.buffer_en = 1'b1;
    apply_config(c);
    send_tick(mk(600, 400, 100, 3'b111, 1000, 511, 15, 255));
    send_tick(mk(600, 400, 100, 3'b101, 1000, 511, 15, 255));
    send_tick(mk(600, 400, 100, 3'b110, 1000, 511, 15, 255));
    send_tick(mk(600, 400, 100, 3'b100, 1000, 511, 15, 255));

    for (int p = 0; p < 14; p++) begin
      settle();
      case (p)
        2: c = '{1'b1, 1'b1, 9'd0, -10'sd200, 12'd2500, 11'd1500, 10'd1000};
        3: c = '{1'b1, 1'b0, 9'd500, 10'sd500, 12'd0, 11'd0, 10'd0};
        5: c = '{1'b1, 1'b0, 9'd0, -10'sd200, 12'd2500, 11'd1500, 10'd1000};
        default: c = rand_cfg();
      endcase
      apply_config(c);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 67; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 67; end
        default: begin gap_pct = 37; stall_pct <= 37; end
      endcase
      if (p == 7) begin
        gap_pct = 0;
        hold_ask <= hold_ask + 1;
      end
      for (int i = 0; i < 82; i++) send_tick(rand_tick(p == 5));
    end
    settle();

    $display("Sent %0d requests over %0d register settings; %0d results checked.",
             board.ticks, settings, board.checked);
    $display("Results with saturated lifetime yield: %0d.", board.saturated);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/sdpc_pkg.sv
hdl/sdpc_eval.sv
hdl/sdpc_mul.sv
hdl/solar_differential_pump_control.sv
hdl/sdpc_checker.sv
sim/tb_solar_differential_pump_control.sv
